// ===== design/dbrp_pkg.sv =====
// Shared types, constants and helper functions for the daily bar record parser.
package dbrp_pkg;

    // Record layout
    localparam int RECORD_BYTES_DEF = 32;   // bytes per record, 28..64
    localparam int FIELD_BYTES      = 28;   // bytes that carry fields (offsets 0..27)

    // Counter and limit widths
    localparam int CNT_W = 21;
    localparam logic [CNT_W-1:0] MAX_REC_RESET = 21'h100000;

    // Configuration space: one 32-bit register per word
    localparam int REG_IDX_W = 1;
    localparam int ADDR_W    = REG_IDX_W + 2;
    localparam logic [REG_IDX_W-1:0] REG_MAX_RECORDS = 1'b0;

    // Result queue
    localparam int RES_DEPTH = 4;
    localparam int RES_PTR_W = $clog2(RES_DEPTH);
    localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

    // Calendar limits
    localparam logic [18:0] YEAR_MIN = 19'd1900;
    localparam logic [18:0] YEAR_MAX = 19'd2200;

    // Divide by 10000 of a 32-bit value: (x * DIV10K_MUL) >> DIV10K_SHIFT
    localparam logic [31:0] DIV10K_MUL   = 32'hD1B71759;
    localparam int          DIV10K_SHIFT = 45;
    // Divide by 100 of a value below 10000: (x * DIV100_MUL) >> DIV100_SHIFT
    localparam logic [12:0] DIV100_MUL   = 13'd5243;
    localparam int          DIV100_SHIFT = 19;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_DATE = 2'd1,
        ST_PARTIAL  = 2'd2,
        ST_TOO_MANY = 2'd3
    } status_t;

    typedef struct packed {
        logic [31:0]        bar_date;
        logic signed [31:0] open_raw;
        logic signed [31:0] high_raw;
        logic signed [31:0] low_raw;
        logic signed [31:0] close_raw;
        logic [31:0]        amount_bits;
        logic [31:0]        volume;
        logic               price_suspicious;
        status_t            status;
        logic [CNT_W-1:0]   record_count;
        logic [CNT_W-1:0]   suspicious_count;
        logic               is_final;
    } res_t;

    // Push request from the record logic into the result queue
    typedef struct packed {
        logic push_first;
        logic push_second;
        res_t first;
        res_t second;
    } res_push_t;

    // Days in month, non-leap; 0 for a month that does not exist
    function automatic logic [4:0] month_days(input logic [6:0] m);
        logic [4:0] d;
        unique case (m)
            7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: d = 5'd31;
            7'd4, 7'd6, 7'd9, 7'd11:                    d = 5'd30;
            7'd2:                                       d = 5'd28;
            default:                                    d = 5'd0;
        endcase
        return d;
    endfunction

    // Price not above zero
    function automatic logic not_positive(input logic [31:0] v);
        return (v == 32'd0) || v[31];
    endfunction

endpackage

// ===== design/dbrp_ifs.sv =====
// Valid/ready stream interfaces for the byte input and the bar result output.
interface dbrp_byte_if;
    logic       valid;
    logic       ready;
    logic       has_byte;
    logic [7:0] file_byte;
    logic       end_of_file;

    modport source (output valid, has_byte, file_byte, end_of_file, input ready);
    modport sink   (input valid, has_byte, file_byte, end_of_file, output ready);
endinterface

interface dbrp_bar_if;
    logic               valid;
    logic               ready;
    logic [31:0]        bar_date;
    logic signed [31:0] open_raw;
    logic signed [31:0] high_raw;
    logic signed [31:0] low_raw;
    logic signed [31:0] close_raw;
    logic [31:0]        amount_bits;
    logic [31:0]        volume;
    logic               price_suspicious;
    logic [1:0]         status;
    logic [20:0]        record_count;
    logic [20:0]        suspicious_count;
    logic               is_final;

    modport source (output valid, bar_date, open_raw, high_raw, low_raw, close_raw,
                    amount_bits, volume, price_suspicious, status, record_count,
                    suspicious_count, is_final, input ready);
    modport sink   (input valid, bar_date, open_raw, high_raw, low_raw, close_raw,
                    amount_bits, volume, price_suspicious, status, record_count,
                    suspicious_count, is_final, output ready);
endinterface

// ===== design/dbrp_cfg.sv =====
// APB register block holding the record limit.
module dbrp_cfg
    import dbrp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output logic [CNT_W-1:0]  max_records
);

    logic [CNT_W-1:0]     max_rec_reg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_max;

    assign reg_idx = paddr[ADDR_W-1:2];
    assign wr_max  = psel && penable && pwrite && (reg_idx == REG_MAX_RECORDS);
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_rec_reg <= MAX_REC_RESET;
        end
        else if (wr_max)
        begin
            max_rec_reg <= pwdata[CNT_W-1:0];
        end
    end

    always_comb
    begin
        prdata = 32'd0;
        if (psel && (reg_idx == REG_MAX_RECORDS))
        begin
            prdata = {{(32-CNT_W){1'b0}}, max_rec_reg};
        end
    end

    assign max_records = max_rec_reg;

endmodule

// ===== design/dbrp_date_chk.sv =====
// Four-stage calendar check of a yyyymmdd date word.
module dbrp_date_chk
    import dbrp_pkg::*;
(
    input  logic        clk,
    input  logic [31:0] date,
    output logic        date_ok
);

    // stage 1: year by reciprocal multiply
    logic [63:0] y_prod;
    logic [31:0] date1_reg;
    logic [18:0] y1_reg;
    // stage 2: remainder mmdd
    logic [31:0] y_times;
    logic [13:0] rem2_reg;
    logic [18:0] y2_reg;
    // stage 3: month
    logic [26:0] m_prod;
    logic [13:0] rem3_reg;
    logic [6:0]  m3_reg;
    logic [18:0] y3_reg;
    // stage 4: day and check
    logic [13:0] m_times;
    logic [6:0]  dd;
    logic        leap;
    logic        ok;
    logic        ok_reg;

    assign y_prod  = {32'd0, date} * {32'd0, DIV10K_MUL};
    assign y_times = {13'd0, y1_reg} * 32'd10000;
    assign m_prod  = {13'd0, rem2_reg} * {14'd0, DIV100_MUL};
    assign m_times = {7'd0, m3_reg} * 14'd100;
    assign dd      = 7'(rem3_reg - m_times);

    // only years 1900..2200 reach here as valid; 2000 is the one leap century
    assign leap = (y3_reg[1:0] == 2'b00) && (y3_reg != 19'd1900) &&
                  (y3_reg != 19'd2100) && (y3_reg != 19'd2200);

    always_comb
    begin
        ok = 1'b0;
        if ((y3_reg >= YEAR_MIN) && (y3_reg <= YEAR_MAX) && (m3_reg >= 7'd1) &&
            (m3_reg <= 7'd12) && (dd >= 7'd1))
        begin
            ok = (dd <= {2'b00, month_days(m3_reg)}) ||
                 ((m3_reg == 7'd2) && leap && (dd == 7'd29));
        end
    end

    always_ff @(posedge clk)
    begin
        date1_reg <= date;
        y1_reg    <= y_prod[DIV10K_SHIFT+18:DIV10K_SHIFT];
        rem2_reg  <= 14'(date1_reg - y_times);
        y2_reg    <= y1_reg;
        rem3_reg  <= rem2_reg;
        m3_reg    <= m_prod[DIV100_SHIFT+6:DIV100_SHIFT];
        y3_reg    <= y2_reg;
        ok_reg    <= ok;
    end

    assign date_ok = ok_reg;

endmodule

// ===== design/dbrp_res_fifo.sv =====
// Small result queue taking up to two results per cycle and giving one.
module dbrp_res_fifo
    import dbrp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  res_push_t push,
    input  logic      pop,
    output logic      not_empty,
    output logic      has_room2,
    output res_t      head
);

    res_t                 mem [RES_DEPTH];
    logic [RES_PTR_W-1:0] wp_reg, wp_next;
    logic [RES_PTR_W-1:0] rp_reg, rp_next;
    logic [RES_CNT_W-1:0] cnt_reg, cnt_next;
    logic [RES_PTR_W-1:0] wp_plus1;

    assign wp_plus1 = wp_reg + 1'b1;

    always_comb
    begin
        wp_next = wp_reg;
        if (push.push_first && push.push_second)
        begin
            wp_next = wp_reg + RES_PTR_W'(2);
        end
        else if (push.push_first)
        begin
            wp_next = wp_plus1;
        end
        rp_next  = pop ? rp_reg + 1'b1 : rp_reg;
        cnt_next = cnt_reg + RES_CNT_W'(push.push_first) + RES_CNT_W'(push.push_second)
                   - RES_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.push_first)
        begin
            mem[wp_reg] <= push.first;
        end
        if (push.push_second)
        begin
            mem[wp_plus1] <= push.second;
        end
    end

    assign not_empty = (cnt_reg != '0);
    assign has_room2 = (cnt_reg <= RES_CNT_W'(RES_DEPTH - 2));
    assign head      = mem[rp_reg];

endmodule

// ===== design/daily_bar_record_parser_core.sv =====
// Top level of the daily bar record parser: byte intake, record checks, result queue.
//
//  channel   | dir | handshake       | payload
//  ----------+-----+-----------------+---------------------------------------------
//  byte_in   | in  | valid / ready   | has_byte, file_byte, end_of_file
//  bar_out   | out | valid / ready   | bar fields, flag, status, counts, is_final
//  apb       | in  | psel / penable  | paddr, pwdata -> prdata (max_records)
//
//  One byte is taken per cycle; its state update and results are worked out in
//  the cycle of the transfer and written into a four-entry result queue.
//  byte_in.ready is high while the queue has room for two results, so the
//  parser keeps one byte per cycle while bar_out drains one result per cycle.
//  The date check is a four-stage pipeline fed from the stored date bytes;
//  it settles before the record's last byte arrives.
//  rst_n clears all control state at once; there is no clearing pass.
module daily_bar_record_parser_core
    import dbrp_pkg::*;
#(
    parameter int RECORD_BYTES = RECORD_BYTES_DEF
)(
    input  logic              clk,
    input  logic              rst_n,
    dbrp_byte_if.sink         byte_in,
    dbrp_bar_if.source        bar_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int POS_W = $clog2(RECORD_BYTES);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(RECORD_BYTES - 1);

    // File state
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [CNT_W-1:0] seen_reg, seen_next;
    logic [CNT_W-1:0] sus_cnt_reg, sus_cnt_next;
    status_t          err_reg, err_next;

    // Field bytes of the current record (bytes past offset 27 are only counted)
    logic [7:0] rec_bytes_reg [FIELD_BYTES];
    logic [7:0] view [FIELD_BYTES];

    logic [CNT_W-1:0] max_records;
    logic             date_ok;
    logic             accept;
    logic             take_byte;
    logic             last_byte;
    logic             rec_check;
    logic             too_many;
    logic             emit;
    logic             eof;
    logic [POS_W-1:0] pos_after;
    status_t          err_after;
    logic [CNT_W-1:0] seen_after;
    logic [CNT_W-1:0] sus_after;
    logic             sus;
    logic [31:0]      open_w, high_w, low_w, close_w, amt_w;
    res_t             rec_res;
    res_t             sum_res;
    res_push_t        push;
    logic             q_not_empty;
    logic             q_room2;
    res_t             q_head;

    function automatic logic [31:0] le32(input logic [7:0] b0, input logic [7:0] b1,
                                         input logic [7:0] b2, input logic [7:0] b3);
        return {b3, b2, b1, b0};
    endfunction

    dbrp_cfg u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .max_records (max_records)
    );

    // Date is settled long before the record closes
    dbrp_date_chk u_date (
        .clk     (clk),
        .date    (le32(rec_bytes_reg[0], rec_bytes_reg[1], rec_bytes_reg[2],
                       rec_bytes_reg[3])),
        .date_ok (date_ok)
    );

    assign accept    = byte_in.valid && byte_in.ready;
    assign take_byte = accept && byte_in.has_byte;
    assign last_byte = take_byte && (pos_reg == POS_LAST);
    assign eof       = accept && byte_in.end_of_file;

    // Byte store: only while no error is pending
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < FIELD_BYTES; k++)
        begin
            if (take_byte && (err_reg == ST_OK) && (pos_reg == POS_W'(k)))
            begin
                rec_bytes_reg[k] <= byte_in.file_byte;
            end
        end
    end

    // Record view with the byte in flight merged in (volume may close the record)
    always_comb
    begin
        for (int k = 0; k < FIELD_BYTES; k++)
        begin
            view[k] = (pos_reg == POS_W'(k)) ? byte_in.file_byte : rec_bytes_reg[k];
        end
    end

    assign open_w  = le32(view[4],  view[5],  view[6],  view[7]);
    assign high_w  = le32(view[8],  view[9],  view[10], view[11]);
    assign low_w   = le32(view[12], view[13], view[14], view[15]);
    assign close_w = le32(view[16], view[17], view[18], view[19]);
    assign amt_w   = le32(view[20], view[21], view[22], view[23]);
    assign sus     = not_positive(open_w) || not_positive(high_w) ||
                     not_positive(low_w) || not_positive(close_w);

    // Record close: date check first, then the limit
    assign rec_check = last_byte && (err_reg == ST_OK);
    assign too_many  = rec_check && date_ok && (seen_reg >= max_records);
    assign emit      = rec_check && date_ok && !too_many;

    always_comb
    begin
        if (last_byte)
        begin
            pos_after = '0;
        end
        else if (take_byte)
        begin
            pos_after = pos_reg + 1'b1;
        end
        else
        begin
            pos_after = pos_reg;
        end

        priority if (rec_check && !date_ok)
        begin
            err_after = ST_BAD_DATE;
        end
        else if (too_many)
        begin
            err_after = ST_TOO_MANY;
        end
        else
        begin
            err_after = err_reg;
        end

        seen_after = seen_reg + CNT_W'(emit);
        sus_after  = sus_cnt_reg + CNT_W'(emit && sus);
    end

    // End of file returns the file state to reset
    always_comb
    begin
        if (eof)
        begin
            pos_next     = '0;
            err_next     = ST_OK;
            seen_next    = '0;
            sus_cnt_next = '0;
        end
        else
        begin
            pos_next     = pos_after;
            err_next     = err_after;
            seen_next    = seen_after;
            sus_cnt_next = sus_after;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            err_reg     <= ST_OK;
            seen_reg    <= '0;
            sus_cnt_reg <= '0;
        end
        else
        begin
            pos_reg     <= pos_next;
            err_reg     <= err_next;
            seen_reg    <= seen_next;
            sus_cnt_reg <= sus_cnt_next;
        end
    end

    // Result words
    always_comb
    begin
        rec_res                  = '0;
        rec_res.bar_date         = le32(rec_bytes_reg[0], rec_bytes_reg[1],
                                        rec_bytes_reg[2], rec_bytes_reg[3]);
        rec_res.open_raw         = open_w;
        rec_res.high_raw         = high_w;
        rec_res.low_raw          = low_w;
        rec_res.close_raw        = close_w;
        rec_res.amount_bits      = (amt_w[30:23] == 8'hFF) ? 32'd0 : amt_w;
        rec_res.volume           = le32(view[24], view[25], view[26], view[27]);
        rec_res.price_suspicious = sus;
        rec_res.status           = ST_OK;
        rec_res.record_count     = seen_after;
        rec_res.suspicious_count = sus_after;
        rec_res.is_final         = 1'b0;

        sum_res                  = '0;
        sum_res.status           = (pos_after != '0) ? ST_PARTIAL : err_after;
        sum_res.record_count     = seen_after;
        sum_res.suspicious_count = sus_after;
        sum_res.is_final         = 1'b1;
    end

    assign push.push_first  = emit || eof;
    assign push.push_second = emit && eof;
    assign push.first       = emit ? rec_res : sum_res;
    assign push.second      = sum_res;

    dbrp_res_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .pop       (bar_out.valid && bar_out.ready),
        .not_empty (q_not_empty),
        .has_room2 (q_room2),
        .head      (q_head)
    );

    assign byte_in.ready = q_room2;

    assign bar_out.valid            = q_not_empty;
    assign bar_out.bar_date         = q_head.bar_date;
    assign bar_out.open_raw         = q_head.open_raw;
    assign bar_out.high_raw         = q_head.high_raw;
    assign bar_out.low_raw          = q_head.low_raw;
    assign bar_out.close_raw        = q_head.close_raw;
    assign bar_out.amount_bits      = q_head.amount_bits;
    assign bar_out.volume           = q_head.volume;
    assign bar_out.price_suspicious = q_head.price_suspicious;
    assign bar_out.status           = q_head.status;
    assign bar_out.record_count     = q_head.record_count;
    assign bar_out.suspicious_count = q_head.suspicious_count;
    assign bar_out.is_final         = q_head.is_final;

endmodule

// ===== design/dbrp_checker.sv =====
// Port-level checks of the parser core, bound to the top level.
module dbrp_checker
    import dbrp_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             in_ready,
    input logic             out_valid,
    input logic             out_ready,
    input logic [31:0]      out_bar_date,
    input logic [1:0]       out_status,
    input logic [CNT_W-1:0] out_record_count,
    input logic [CNT_W-1:0] out_suspicious_count,
    input logic             out_is_final
);

    // Intake only stalls while results are waiting
    a_stall_has_results: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled with no result pending");

    // A bar result is always clean and counted
    a_bar_counted: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_is_final |-> (out_status == ST_OK) && (out_record_count != '0))
        else $error("bar result with error status or zero count");

    // Flagged bars never outnumber accepted bars
    a_sus_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_suspicious_count <= out_record_count))
        else $error("suspicious count above record count");

    // Held result stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_bar_date) &&
                                    $stable(out_record_count) && $stable(out_is_final))
        else $error("stalled result changed");

endmodule

bind daily_bar_record_parser_core dbrp_checker u_dbrp_checker (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_ready             (byte_in.ready),
    .out_valid            (bar_out.valid),
    .out_ready            (bar_out.ready),
    .out_bar_date         (bar_out.bar_date),
    .out_status           (bar_out.status),
    .out_record_count     (bar_out.record_count),
    .out_suspicious_count (bar_out.suspicious_count),
    .out_is_final         (bar_out.is_final)
);

// ===== tb/daily_bar_record_parser_core_tb.sv =====
// Self-checking testbench for daily_bar_record_parser_core: byte stream in, bar records out.
`timescale 1ns / 1ps

module daily_bar_record_parser_core_tb;
    import dbrp_pkg::*;

    // Run shape
    localparam int SETTLE_CYCLES = 8;     // covers the 4-stage date pipeline and the result queue
    localparam int QUIET_LIMIT   = 1000;  // cycles with no transfer before the run is declared hung
    localparam int PHASE_BYTES   = 40;    // random file bytes per limit setting, at least
    localparam int NUM_PHASES    = 6;

    // One item of the byte channel
    typedef struct packed {
        logic       has_byte;
        logic [7:0] file_byte;
        logic       end_of_file;
    } file_item_t;

    logic clk = 1'b0;
    logic rst_n;

    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    dbrp_byte_if byte_in();
    dbrp_bar_if  bar_out();

    daily_bar_record_parser_core u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .byte_in (byte_in),
        .bar_out (bar_out),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Bar predictor: mirror of the parser state, updated per accepted byte
    // ------------------------------------------------------------------
    file_item_t  byte_backlog[$];    // items waiting for the driver
    res_t        bars_due[$];        // bar records and file summaries still to come
    logic [7:0]  rec_buf[RECORD_BYTES_DEF];
    int          rec_pos;
    logic [20:0] bars_taken;
    logic [20:0] flagged_taken;
    logic [20:0] bar_limit;
    status_t     file_err;

    int          planned_bytes;
    int          mismatches;
    int          quiet_cycles;

    function automatic logic leap_year(input int unsigned yr);
        return ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
    endfunction

    function automatic int unsigned month_len(input int unsigned yr, input int unsigned mo);
        case (mo)
            4, 6, 9, 11: return 30;
            2:           return leap_year(yr) ? 29 : 28;
            default:     return 31;
        endcase
    endfunction

    // yyyymmdd must name a real day between 1900 and 2200
    function automatic logic date_ok(input logic [31:0] d);
        int unsigned dv;
        int unsigned yr;
        int unsigned mo;
        int unsigned dy;
        dv = d;
        yr = dv / 10000;
        mo = (dv / 100) % 100;
        dy = dv % 100;
        if (yr < 1900 || yr > 2200 || mo < 1 || mo > 12 || dy < 1)
            return 1'b0;
        return dy <= month_len(yr, mo);
    endfunction

    function automatic logic price_bad(input logic [31:0] v);
        return (v == 32'd0) || v[31];
    endfunction

    function automatic logic [31:0] buf_word(input int off);
        return {rec_buf[off + 3], rec_buf[off + 2], rec_buf[off + 1], rec_buf[off]};
    endfunction

    task automatic parse_byte(input logic has, input logic [7:0] b, input logic eof);
        res_t        bar;
        logic [31:0] date;
        logic [31:0] amount;
        if (has)
        begin
            // after the first error bytes only count toward the length check
            if (file_err == ST_OK)
                rec_buf[rec_pos] = b;
            if (rec_pos < RECORD_BYTES_DEF - 1)
                rec_pos++;
            else
            begin
                rec_pos = 0;
                if (file_err == ST_OK)
                begin
                    date = buf_word(0);
                    if (!date_ok(date))
                        file_err = ST_BAD_DATE;
                    else if (bars_taken >= bar_limit)
                        file_err = ST_TOO_MANY;
                    else
                    begin
                        bar = '0;
                        bar.bar_date  = date;
                        bar.open_raw  = buf_word(4);
                        bar.high_raw  = buf_word(8);
                        bar.low_raw   = buf_word(12);
                        bar.close_raw = buf_word(16);
                        amount = buf_word(20);
                        // non-finite amounts (exponent all ones) read as zero
                        bar.amount_bits = (amount[30:23] == 8'hFF) ? 32'd0 : amount;
                        bar.volume      = buf_word(24);
                        bar.price_suspicious = price_bad(bar.open_raw) ||
                                               price_bad(bar.high_raw) ||
                                               price_bad(bar.low_raw) ||
                                               price_bad(bar.close_raw);
                        bars_taken++;
                        if (bar.price_suspicious)
                            flagged_taken++;
                        bar.status           = ST_OK;
                        bar.record_count     = bars_taken;
                        bar.suspicious_count = flagged_taken;
                        bar.is_final         = 1'b0;
                        bars_due.push_back(bar);
                    end
                end
            end
        end
        if (eof)
        begin
            // a torn last record wins over any earlier error
            bar = '0;
            bar.status           = (rec_pos != 0) ? ST_PARTIAL : file_err;
            bar.record_count     = bars_taken;
            bar.suspicious_count = flagged_taken;
            bar.is_final         = 1'b1;
            bars_due.push_back(bar);
            rec_pos       = 0;
            bars_taken    = '0;
            flagged_taken = '0;
            file_err      = ST_OK;
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers: files are built into byte_backlog in zero time
    // ------------------------------------------------------------------
    task automatic push_noise();
        byte_backlog.push_back('{1'b0, 8'($urandom_range(0, 255)), 1'b0});
    endtask

    task automatic push_byte(input logic [7:0] b);
        // sprinkle ignored items (no byte, no end) through the stream
        if ($urandom_range(0, 39) == 0)
            push_noise();
        byte_backlog.push_back('{1'b1, b, 1'b0});
        planned_bytes++;
    endtask

    // bare end marker; the byte field carries junk
    task automatic push_marker();
        byte_backlog.push_back('{1'b0, 8'($urandom_range(0, 255)), 1'b1});
    endtask

    // end of file rides on the last byte already queued
    task automatic mark_end();
        file_item_t it;
        it = byte_backlog.pop_back();
        it.end_of_file = 1'b1;
        byte_backlog.push_back(it);
    endtask

    task automatic push_record(input logic [31:0] date, input logic [31:0] o,
                               input logic [31:0] h, input logic [31:0] l,
                               input logic [31:0] c, input logic [31:0] amt,
                               input logic [31:0] vol);
        logic [223:0] fields;
        int           k;
        fields = {vol, amt, c, l, h, o, date};
        for (k = 0; k < RECORD_BYTES_DEF; k++)
        begin
            if (k < 28)
                push_byte(fields[8*k +: 8]);
            else
                push_byte(8'($urandom_range(0, 255)));   // padding past the fields
        end
    endtask

    task automatic push_tail(input int n);
        repeat (n) push_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic bad_date_file(input logic [31:0] d);
        push_record(d, 32'd1, 32'd1, 32'd1, 32'd1, 32'd0, 32'd0);
        mark_end();
    endtask

    function automatic logic [31:0] good_date();
        int unsigned yr;
        int unsigned mo;
        case ($urandom_range(0, 7))
            0: return 32'd19000101;
            1: return 32'd22001231;
            2: return 32'd20000229;
            default:
            begin
                yr = $urandom_range(1900, 2200);
                mo = $urandom_range(1, 12);
                return yr * 10000 + mo * 100 + $urandom_range(1, month_len(yr, mo));
            end
        endcase
    endfunction

    function automatic logic [31:0] bad_date();
        int unsigned yr;
        int unsigned mo;
        int unsigned dy;
        yr = $urandom_range(1900, 2200);
        mo = $urandom_range(1, 12);
        dy = $urandom_range(1, 28);
        case ($urandom_range(0, 8))
            0: yr = $urandom_range(0, 1899);
            1: yr = $urandom_range(2201, 429496);
            2: mo = 0;
            3: mo = $urandom_range(13, 99);
            4: dy = 0;
            5: dy = $urandom_range(month_len(yr, mo) + 1, 99);
            6:
            begin
                // Feb 29 in a year that has none
                case ($urandom_range(0, 3))
                    0: yr = 1900;
                    1: yr = 2100;
                    2: yr = 2200;
                    default: yr = 2001 + 4 * $urandom_range(0, 20);
                endcase
                mo = 2;
                dy = 29;
            end
            7: return $urandom;
            default: return ($urandom_range(0, 1) == 0) ? 32'd0 : 32'hFFFFFFFF;
        endcase
        return yr * 10000 + mo * 100 + dy;
    endfunction

    function automatic logic [31:0] pick_price();
        case ($urandom_range(0, 31))
            0: return 32'd0;
            1: return 32'h80000000;
            2: return 32'h7FFFFFFF;
            3: return 32'd1;
            4: return -$urandom_range(1, 100000);
            5: return $urandom;
            default: return $urandom_range(1, 5000000);
        endcase
    endfunction

    function automatic logic [31:0] pick_amount();
        case ($urandom_range(0, 7))
            0: return {1'($urandom_range(0, 1)), 8'hFF, 23'($urandom)};
            1: return 32'd0;
            default: return $urandom;
        endcase
    endfunction

    // Mostly clean files: whole records, good dates, a proper end.
    // Now and then a bad date somewhere or a torn last record.
    task automatic random_file();
        int nrec;
        int bad_idx;
        int k;
        int ending;
        nrec    = $urandom_range(0, 3);
        bad_idx = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 3) : -1;
        for (k = 0; k < nrec; k++)
            push_record((k == bad_idx) ? bad_date() : good_date(), pick_price(),
                        pick_price(), pick_price(), pick_price(), pick_amount(), $urandom);
        ending = $urandom_range(0, 7);
        if (nrec == 0 && ending < 3)
            ending = 3;
        if (ending >= 6)
            push_tail($urandom_range(1, RECORD_BYTES_DEF - 1));
        if (ending == 3 || ending == 4 || ending == 5 || ending == 7)
            push_marker();
        else
            mark_end();
    endtask

    // ------------------------------------------------------------------
    // Configuration and phase control
    // ------------------------------------------------------------------
    task automatic set_limit(input logic [20:0] lim);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_MAX_RECORDS, 2'b00};
        pwdata  <= {11'd0, lim};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        bar_limit = lim;
    endtask

    // wait for every queued byte to go and every expected result to arrive
    task automatic drain();
        while (byte_backlog.size() != 0 || byte_in.valid || bars_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [20:0] phase_limit(input int ph);
        case (ph)
            0: return MAX_REC_RESET;
            1: return 21'd1;
            2: return 21'd0;
            3: return 21'd2;
            4: return 21'($urandom_range(1, 4));
            default: return MAX_REC_RESET;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Byte driver: one transfer per handshake, random gap after each item,
    // with stretches of back-to-back traffic
    // ------------------------------------------------------------------
    file_item_t  next_item;
    int unsigned send_wait;
    logic        send_steady;

    function automatic int unsigned pick_gap(input logic steady);
        if (steady)
            return 0;
        return $urandom_range(0, 17);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_in.valid       <= 1'b0;
            byte_in.has_byte    <= 1'b0;
            byte_in.file_byte   <= 8'd0;
            byte_in.end_of_file <= 1'b0;
            send_wait           <= 0;
        end
        else
        begin
            if (byte_in.valid && byte_in.ready)
                parse_byte(byte_in.has_byte, byte_in.file_byte, byte_in.end_of_file);
            if (!byte_in.valid || byte_in.ready)
            begin
                if (send_wait != 0)
                begin
                    byte_in.valid <= 1'b0;
                    send_wait     <= send_wait - 1;
                end
                else if (byte_backlog.size() != 0)
                begin
                    next_item = byte_backlog.pop_front();
                    byte_in.valid       <= 1'b1;
                    byte_in.has_byte    <= next_item.has_byte;
                    byte_in.file_byte   <= next_item.file_byte;
                    byte_in.end_of_file <= next_item.end_of_file;
                    if ($urandom_range(0, 47) == 0)
                        send_steady = !send_steady;
                    send_wait <= pick_gap(send_steady);
                end
                else
                    byte_in.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Bar monitor: random stall after each result, field-by-field compare
    // ------------------------------------------------------------------
    int unsigned take_wait;
    int unsigned take_gap;
    logic        take_steady;

    task automatic match_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %h, got %h", field, want, got);
            mismatches++;
        end
    endtask

    task automatic check_bar();
        res_t want;
        if (bars_due.size() == 0)
        begin
            $error("bar result with nothing expected: date %h, is_final %b",
                   bar_out.bar_date, bar_out.is_final);
            mismatches++;
        end
        else
        begin
            want = bars_due.pop_front();
            match_field("bar_date", want.bar_date, bar_out.bar_date);
            match_field("open_raw", want.open_raw, bar_out.open_raw);
            match_field("high_raw", want.high_raw, bar_out.high_raw);
            match_field("low_raw", want.low_raw, bar_out.low_raw);
            match_field("close_raw", want.close_raw, bar_out.close_raw);
            match_field("amount_bits", want.amount_bits, bar_out.amount_bits);
            match_field("volume", want.volume, bar_out.volume);
            match_field("price_suspicious", want.price_suspicious, bar_out.price_suspicious);
            match_field("status", want.status, bar_out.status);
            match_field("record_count", want.record_count, bar_out.record_count);
            match_field("suspicious_count", want.suspicious_count, bar_out.suspicious_count);
            match_field("is_final", want.is_final, bar_out.is_final);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bar_out.ready <= 1'b0;
            take_wait     <= 0;
        end
        else
        begin
            if (bar_out.valid && bar_out.ready)
            begin
                check_bar();
                if ($urandom_range(0, 31) == 0)
                    take_steady = !take_steady;
                take_gap = pick_gap(take_steady);
                take_wait     <= take_gap;
                bar_out.ready <= (take_gap == 0);
            end
            else if (take_wait != 0)
            begin
                take_wait     <= take_wait - 1;
                bar_out.ready <= (take_wait == 1);
            end
            else
                bar_out.ready <= 1'b1;
        end
    end

    // Watchdog: a long stretch with no transfer on either channel means a hang
    always @(posedge clk)
    begin
        if (!rst_n || (byte_in.valid && byte_in.ready) || (bar_out.valid && bar_out.ready) || psel)
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ------------------------------------------------------------------
    // Sequence: reset, directed files, then random files under several limits
    // ------------------------------------------------------------------
    initial
    begin
        int ph;
        int phase_end;

        rst_n               = 1'b0;
        byte_in.valid       = 1'b0;
        byte_in.has_byte    = 1'b0;
        byte_in.file_byte   = 8'd0;
        byte_in.end_of_file = 1'b0;
        bar_out.ready       = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = 32'd0;
        rec_pos             = 0;
        bars_taken          = '0;
        flagged_taken       = '0;
        file_err            = ST_OK;
        bar_limit           = MAX_REC_RESET;
        planned_bytes       = 0;
        mismatches          = 0;
        quiet_cycles        = 0;
        send_steady         = 1'b0;
        take_steady         = 1'b0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // calendar edges, price extremes, infinite and NaN amounts; limit at reset value
        push_record(32'd19000101, 32'd1, 32'h7FFFFFFF, 32'd1, 32'h7FFFFFFF,
                    32'h3F800000, 32'd0);
        push_noise();
        push_record(32'd22001231, 32'd0, 32'd5, 32'd5, 32'd5, 32'h7F800000, 32'hFFFFFFFF);
        push_record(32'd20000229, 32'h80000000, 32'hFFFFFFFF, 32'd7, 32'd9,
                    32'hFF800001, 32'd12345);
        push_record(32'd20240229, 32'd100, 32'd200, 32'd50, 32'd150, 32'h7F7FFFFF, 32'd1);
        mark_end();

        // empty file: end marker alone
        push_marker();

        // one file per kind of impossible date
        bad_date_file(32'd19000229);   // century, not leap
        bad_date_file(32'd21000229);
        bad_date_file(32'd20230229);
        bad_date_file(32'd18991231);   // year below range
        bad_date_file(32'd22010101);   // year above range
        bad_date_file(32'd20231301);   // month 13
        bad_date_file(32'd20230001);   // month 0
        bad_date_file(32'd20230100);   // day 0
        bad_date_file(32'd20230431);   // April 31
        bad_date_file(32'hFFFFFFFF);

        // bad date mid-file: later good record is swallowed, torn tail reports partial
        push_record(32'd20200615, 32'd10, 32'd12, 32'd9, 32'd11, 32'h41200000, 32'd500);
        push_record(32'd20230229, 32'd10, 32'd12, 32'd9, 32'd11, 32'h41200000, 32'd500);
        push_record(32'd20200616, 32'd10, 32'd12, 32'd9, 32'd11, 32'h41200000, 32'd500);
        push_tail(3);
        mark_end();

        // short file, ends inside the first record
        push_tail(5);
        mark_end();
        drain();

        // zero limit: every good record is one too many
        set_limit(21'd0);
        push_record(good_date(), 32'd3, 32'd4, 32'd2, 32'd3, 32'd0, 32'd7);
        push_record(good_date(), 32'd3, 32'd4, 32'd2, 32'd3, 32'd0, 32'd7);
        push_marker();
        drain();

        // limit of one: first record passes, second trips the limit, third ignored
        set_limit(21'd1);
        push_record(good_date(), 32'd3, 32'd0, 32'd2, 32'd3, 32'd0, 32'd7);
        push_record(good_date(), 32'd3, 32'd4, 32'd2, 32'd3, 32'd0, 32'd7);
        push_record(good_date(), 32'd3, 32'd4, 32'd2, 32'd3, 32'd0, 32'd7);
        mark_end();
        drain();

        // random files, a different limit per phase
        for (ph = 0; ph < NUM_PHASES; ph++)
        begin
            set_limit(phase_limit(ph));
            phase_end = planned_bytes + PHASE_BYTES;
            while (planned_bytes < phase_end)
                random_file();
            drain();
        end

        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/dbrp_pkg.sv
design/dbrp_ifs.sv
design/dbrp_cfg.sv
design/dbrp_date_chk.sv
design/dbrp_res_fifo.sv
design/daily_bar_record_parser_core.sv
design/dbrp_checker.sv
tb/daily_bar_record_parser_core_tb.sv
